// ===== hdl/dgid_pkg.sv =====
// Shared types and constants for the DPCM/GAP image decoder.
// No dependencies; imported by dgid_front, dgid_back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package dgid_pkg;

    // Residual class, decided in the front end
    typedef enum logic [1:0] {
        SYM_ZERO,
        SYM_ONE,
        SYM_ESC,
        SYM_NONE
    } sym_t;

    typedef struct packed {
        logic signed [8:0] residual;
        sym_t              sym;
    } item_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic       last_pixel;
    } result_t;

    typedef struct packed {
        logic [10:0] image_width;
        logic [15:0] image_height;
        logic [2:0]  predictor_mode;
    } cfg_t;

    // Register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_MODE   = 2'd2;

    localparam logic [10:0] WIDTH_RESET  = 11'd256;
    localparam logic [15:0] HEIGHT_RESET = 16'd256;

    // Predictor modes
    localparam logic [2:0] MODE_WEST  = 3'd1;
    localparam logic [2:0] MODE_NORTH = 3'd2;
    localparam logic [2:0] MODE_AVG   = 3'd3;
    localparam logic [2:0] MODE_CALIC = 3'd4;

    localparam int MIN_WIDTH = 3;

    localparam logic signed [12:0] FIRST_PRED = 13'sd128;
    localparam logic signed [12:0] GAP_STRONG = 13'sd80;
    localparam logic signed [12:0] GAP_MID    = 13'sd32;
    localparam logic signed [12:0] GAP_WEAK   = 13'sd8;
    localparam logic signed [12:0] PIX_MAX    = 13'sd255;

endpackage

`default_nettype wire

// ===== hdl/dgid_fifo.sv =====
// Small register-based FIFO used between decoder stages and at the output.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module dgid_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dgid_front.sv =====
// Front end: takes residuals, tags binary-mode symbols, queues them.
// Depends on dgid_pkg and dgid_fifo.
`timescale 1ns / 1ps
`default_nettype none

module dgid_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic signed [8:0] residual,
    input  wire logic             q_pop,
    output logic                  q_empty,
    output dgid_pkg::item_t       q_item
);
    import dgid_pkg::*;

    item_t            item_in;
    logic [$bits(item_t)-1:0] q_raw;

    always_comb
    begin
        item_in.residual = residual;
        priority if (residual == 9'sd0)
            item_in.sym = SYM_ZERO;
        else if (residual == 9'sd1)
            item_in.sym = SYM_ONE;
        else if (residual == 9'sd2)
            item_in.sym = SYM_ESC;
        else
            item_in.sym = SYM_NONE;
    end

    dgid_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (2)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (item_in),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_raw),
        .empty (q_empty)
    );

    assign q_item = item_t'(q_raw);

endmodule

`default_nettype wire

// ===== hdl/dgid_back.sv =====
// Back end: prediction, reconstruction, line buffers and raster counters.
// Depends on dgid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dgid_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dgid_pkg::cfg_t  cfg,
    input  wire logic            q_empty,
    input  wire dgid_pkg::item_t q_item,
    output logic                 q_pop,
    input  wire logic            out_full,
    output logic                 out_push,
    output dgid_pkg::result_t    out_data
);
    import dgid_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = (AW + 1 > 11) ? AW + 1 : 11;

    // Line buffers: row above and two rows above
    logic [7:0] north_row_reg [MAX_WIDTH];
    logic [7:0] north_north_row_reg [MAX_WIDTH];
    logic [7:0] ne_reg, nne_reg;          // registered buffer reads

    logic [AW-1:0] col_reg, col_next;
    logic [15:0]   row_reg, row_next;
    logic [7:0]    w_reg, w_next, ww_reg, ww_next;
    logic          esc_reg, esc_next;
    logic [7:0]    n_reg, n_next, nw_reg, nw_next, nn_reg, nn_next;
    logic [7:0]    col0_reg, col0_next;

    logic [WW-1:0] wcfg, width_eff;
    logic [15:0]   height_eff;
    logic          last_col, last, step, escape_now;
    logic [AW-1:0] rd_addr;
    logic [7:0]    nb [7];
    logic [7:0]    s1;
    logic          two_vals, binary;
    logic signed [12:0] pred, res_eff, sum;
    logic [7:0]    val;

    function automatic logic signed [12:0] half_tz(input logic signed [12:0] x);
        return (x + (x[12] ? 13'sd1 : 13'sd0)) >>> 1;
    endfunction

    function automatic logic signed [12:0] quarter_tz(input logic signed [12:0] x);
        return (x + (x[12] ? 13'sd3 : 13'sd0)) >>> 2;
    endfunction

    function automatic logic signed [12:0] absd(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? $signed({5'b0, a - b}) : $signed({5'b0, b - a});
    endfunction

    function automatic logic signed [12:0] gap_pred(
        input logic [7:0] w, input logic [7:0] ww, input logic [7:0] n,
        input logic [7:0] nw, input logic [7:0] ne, input logic [7:0] nn,
        input logic [7:0] nne);
        logic signed [12:0] sw, sn, dh, dv, dvh, dhv, p, r;
        sw  = $signed({5'b0, w});
        sn  = $signed({5'b0, n});
        dh  = absd(w, ww) + absd(n, nw) + absd(ne, n);
        dv  = absd(w, nw) + absd(n, nn) + absd(ne, nne);
        dvh = dv - dh;
        dhv = dh - dv;
        p   = half_tz(sw + sn) + quarter_tz($signed({5'b0, ne}) - $signed({5'b0, nw}));
        priority if (dvh > GAP_STRONG)
            r = sw;
        else if (dhv > GAP_STRONG)
            r = sn;
        else if (dvh > GAP_MID)
            r = half_tz(p + sw);
        else if (dhv > GAP_MID)
            r = half_tz(p + sn);
        else if (dvh > GAP_WEAK)
            r = quarter_tz(13'sd3 * p + sw);
        else if (dhv > GAP_WEAK)
            r = quarter_tz(13'sd3 * p + sn);
        else
            r = p;
        return r;
    endfunction

    // Effective geometry
    always_comb
    begin
        wcfg = WW'(cfg.image_width);
        priority if (wcfg < WW'(MIN_WIDTH))
            width_eff = WW'(MIN_WIDTH);
        else if (wcfg > WW'(MAX_WIDTH))
            width_eff = WW'(MAX_WIDTH);
        else
            width_eff = wcfg;
        height_eff = (cfg.image_height == 16'd0) ? 16'd1 : cfg.image_height;
    end

    assign last_col = (WW'(col_reg) + WW'(1)) >= width_eff;
    assign last     = last_col && (({1'b0, row_reg} + 17'd1) >= {1'b0, height_eff});
    assign step     = !q_empty && !out_full;
    assign q_pop    = step;

    // Binary-mode context: s1 is the first neighbor that differs from W
    always_comb
    begin
        nb[0] = w_reg;
        nb[1] = ww_reg;
        nb[2] = n_reg;
        nb[3] = nw_reg;
        nb[4] = ne_reg;
        nb[5] = nn_reg;
        nb[6] = nne_reg;
        s1 = 8'd0;
        for (int k = 6; k >= 1; k--)
        begin
            if (nb[k] != w_reg)
                s1 = nb[k];
        end
        two_vals = 1'b1;
        for (int k = 1; k < 7; k++)
        begin
            if (!(nb[k] == w_reg || nb[k] == s1))
                two_vals = 1'b0;
        end
    end

    // Prediction and reconstruction
    always_comb
    begin
        res_eff    = 13'(q_item.residual);
        escape_now = 1'b0;
        binary     = two_vals && !esc_reg;
        priority if (row_reg == 16'd0 && col_reg == '0)
            pred = FIRST_PRED;
        else if (row_reg == 16'd0)
            pred = $signed({5'b0, w_reg});
        else if (row_reg == 16'd1 || col_reg < AW'(2) || last_col)
            pred = $signed({5'b0, n_reg});
        else if (cfg.predictor_mode == MODE_CALIC)
        begin
            priority if (binary && q_item.sym == SYM_ESC)
            begin
                escape_now = 1'b1;
                pred       = $signed({5'b0, w_reg});
            end
            else if (binary && q_item.sym == SYM_ZERO)
            begin
                pred    = $signed({5'b0, w_reg});
                res_eff = 13'sd0;
            end
            else if (binary && q_item.sym == SYM_ONE)
            begin
                pred    = $signed({5'b0, s1});
                res_eff = 13'sd0;
            end
            else
                pred = gap_pred(w_reg, ww_reg, n_reg, nw_reg, ne_reg, nn_reg, nne_reg);
        end
        else if (cfg.predictor_mode == MODE_WEST)
            pred = $signed({5'b0, w_reg});
        else if (cfg.predictor_mode == MODE_AVG)
            pred = $signed({6'b0, w_reg[7:1]}) + $signed({6'b0, n_reg[7:1]});
        else
            pred = $signed({5'b0, n_reg});   // north and unknown modes

        sum = pred + res_eff;
        priority if (sum < 13'sd0)
            val = 8'd0;
        else if (sum > PIX_MAX)
            val = 8'd255;
        else
            val = sum[7:0];
    end

    assign out_push            = step && !escape_now;
    assign out_data.pixel      = val;
    assign out_data.last_pixel = last;

    // Next pixel reads its NE from col+2 now; after a wrap, column 1 is fetched
    assign rd_addr = last_col ? AW'(1) : col_reg + AW'(2);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        w_next    = w_reg;
        ww_next   = ww_reg;
        esc_next  = esc_reg;
        n_next    = n_reg;
        nw_next   = nw_reg;
        nn_next   = nn_reg;
        col0_next = col0_reg;
        if (step)
            esc_next = escape_now;
        if (out_push)
        begin
            ww_next = w_reg;
            w_next  = val;
            nw_next = n_reg;
            nn_next = nne_reg;
            if (col_reg == '0)
                col0_next = val;
            if (last_col)
            begin
                col_next = '0;
                row_next = last ? 16'd0 : row_reg + 16'd1;
                n_next   = col0_reg;
            end
            else
            begin
                col_next = col_reg + 1'b1;
                n_next   = ne_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            w_reg   <= '0;
            ww_reg  <= '0;
            esc_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            w_reg   <= w_next;
            ww_reg  <= ww_next;
            esc_reg <= esc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        nw_reg   <= nw_next;
        nn_reg   <= nn_next;
        col0_reg <= col0_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            north_row_reg[col_reg]       <= val;
            north_north_row_reg[col_reg] <= n_reg;
            ne_reg                       <= north_row_reg[rd_addr];
            nne_reg                      <= north_north_row_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dpcm_gap_image_decoder_core.sv =====
// Top level of the lossless DPCM/GAP image decoder.
// Depends on dgid_pkg, dgid_front, dgid_back and dgid_fifo.
`timescale 1ns / 1ps
`default_nettype none

// Decodes a raster stream of signed residuals into 8-bit pixels, one
// residual per clock when unstalled. Residuals enter a two-entry queue
// through push/full; the back end takes one per cycle while that queue
// is not empty and the result queue is not full, forms the prediction
// from the west pixel and from two line buffers of MAX_WIDTH bytes each,
// and pushes the pixel into a two-entry result queue read through
// empty/pop. Residual and pixel pass the two registered queues. In CALIC
// mode an escape symbol yields no result; the following residual completes
// the same pixel. Each line buffer is written and read once per pixel, so
// one pixel per cycle is set by that port pair and by the west-pixel loop.
// Line buffer contents are unknown after reset; the first row never uses
// them and the second uses only what the first wrote. Configuration
// writes over cfg_valid/cfg_ready are always taken and should only be
// issued while the decoder is idle.
module dpcm_gap_image_decoder_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic signed [8:0] residual,
    output logic                   empty,
    input  wire logic              pop,
    output logic [7:0]             pixel,
    output logic                   last_pixel,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data
);
    import dgid_pkg::*;

    cfg_t    cfg_reg;
    item_t   q_item;
    logic    q_empty, q_pop;
    logic    out_full, out_push;
    result_t out_data, out_head;
    logic [$bits(result_t)-1:0] out_raw;

    // Configuration registers; index 3 is ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width    <= WIDTH_RESET;
            cfg_reg.image_height   <= HEIGHT_RESET;
            cfg_reg.predictor_mode <= MODE_WEST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  cfg_reg.image_width    <= cfg_data[10:0];
                CFG_HEIGHT: cfg_reg.image_height   <= cfg_data;
                CFG_MODE:   cfg_reg.predictor_mode <= cfg_data[2:0];
                default:    ;
            endcase
        end
    end

    dgid_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .residual (residual),
        .q_pop    (q_pop),
        .q_empty  (q_empty),
        .q_item   (q_item)
    );

    dgid_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .out_full (out_full),
        .out_push (out_push),
        .out_data (out_data)
    );

    // Result queue decouples the decoder from a stalling consumer
    dgid_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (2)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_data),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_raw),
        .empty (empty)
    );

    assign out_head   = result_t'(out_raw);
    assign pixel      = out_head.pixel;
    assign last_pixel = out_head.last_pixel;

endmodule

`default_nettype wire

// ===== hdl/dgid_checker.sv =====
// Port-level checks for the decoder top level, attached by bind.
// Depends on dpcm_gap_image_decoder_core.
`timescale 1ns / 1ps
`default_nettype none

module dgid_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       push,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] pixel,
    input wire logic       last_pixel,
    input wire logic       cfg_ready
);

    // Reset leaves the result queue empty and the input queue not full
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // A waiting result holds until it is popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(pixel) && $stable(last_pixel)))
        else $error("result changed while stalled");

    // The input queue only fills on a residual transfer
    a_full_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a push");

    // Configuration port never stalls
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind dpcm_gap_image_decoder_core dgid_checker u_dgid_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .pixel      (pixel),
    .last_pixel (last_pixel),
    .cfg_ready  (cfg_ready)
);

`default_nettype wire

// ===== tb/sv/dpcm_gap_image_decoder_core_tb.sv =====
// Self-checking testbench for the DPCM/GAP image decoder core.
// Depends on dgid_pkg and dpcm_gap_image_decoder_core; predicts every pixel in SV.
`timescale 1ns / 1ps

module dpcm_gap_image_decoder_core_tb;
    import dgid_pkg::*;

    localparam int LINE_MAX   = 1024;
    localparam int STALL_MAX  = 4000;   // cycles with no transfer before giving up
    localparam int DRAIN_WAIT = 8;      // covers the back end plus queues

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic signed [8:0] residual;
    logic              empty;
    logic              pop;
    logic [7:0]        pixel;
    logic              last_pixel;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [15:0]       cfg_data;

    dpcm_gap_image_decoder_core #(.MAX_WIDTH(LINE_MAX)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .residual   (residual),
        .empty      (empty),
        .pop        (pop),
        .pixel      (pixel),
        .last_pixel (last_pixel),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Residuals waiting for the driver, and pixels waiting for the monitor
    logic signed [8:0] residual_q[$];
    result_t           pixel_q[$];

    int errors;
    int n_sent;
    int n_got;
    int n_items;
    int frames_done;

    // Decoder shadow: configuration, line buffers, neighbours, position
    logic [10:0] sh_width;
    logic [15:0] sh_height;
    logic [2:0]  sh_mode;
    logic [7:0]  north_buf[LINE_MAX];
    logic [7:0]  north2_buf[LINE_MAX];
    logic [7:0]  west_px;
    logic [7:0]  west2_px;
    int          col;
    int          row;
    bit          esc_armed;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int mag(input int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int line_rd(input logic [7:0] buf_v, input int idx);
        return idx < LINE_MAX ? int'(buf_v) : 0;
    endfunction

    // Gradient adjusted prediction; int division truncates toward zero as needed
    function automatic int gap_pred(input int w, input int ww, input int n, input int nw,
                                    input int ne, input int nn, input int nne);
        int dh;
        int dv;
        int p;
        dh = mag(w - ww) + mag(n - nw) + mag(ne - n);
        dv = mag(w - nw) + mag(n - nn) + mag(ne - nne);
        if (dv - dh > int'(GAP_STRONG)) return w;
        if (dh - dv > int'(GAP_STRONG)) return n;
        p = (w + n) / 2 + (ne - nw) / 4;
        if (dv - dh > int'(GAP_MID))       p = (p + w) / 2;
        else if (dh - dv > int'(GAP_MID))  p = (p + n) / 2;
        else if (dv - dh > int'(GAP_WEAK)) p = (3 * p + w) / 4;
        else if (dh - dv > int'(GAP_WEAK)) p = (3 * p + n) / 4;
        return p;
    endfunction

    // Runs one residual through the shadow decoder, queues the pixel it yields
    task automatic decode_residual(input logic signed [8:0] res_in);
        int      wid;
        int      hgt;
        int      c;
        int      r;
        int      res;
        int      w;
        int      n;
        int      pred;
        int      val;
        int      s1;
        int      other;
        int      distinct;
        int      nb[7];
        bit      last_col;
        bit      is_last;
        bit      binary;
        result_t exp_px;
        wid = int'(sh_width);
        if (wid < MIN_WIDTH) wid = MIN_WIDTH;
        if (wid > LINE_MAX) wid = LINE_MAX;
        hgt = sh_height == 16'd0 ? 1 : int'(sh_height);
        c = col;
        r = row;
        res = int'(res_in);
        last_col = (c + 1 >= wid);
        w = int'(west_px);
        n = c < LINE_MAX ? int'(north_buf[c]) : 0;

        if (r == 0 && c == 0)
        begin
            pred = int'(FIRST_PRED);
            esc_armed = 1'b0;
        end
        else if (r == 0)
        begin
            pred = w;
            esc_armed = 1'b0;
        end
        else if (r == 1 || c < 2 || last_col)
        begin
            pred = n;
            esc_armed = 1'b0;
        end
        else if (sh_mode == MODE_CALIC)
        begin
            nb[0] = w;
            nb[1] = int'(west2_px);
            nb[2] = n;
            nb[3] = line_rd(north2_buf[c - 1], c - 1);
            nb[4] = c + 1 < LINE_MAX ? int'(north_buf[c + 1]) : 0;
            nb[5] = int'(north2_buf[c]);
            nb[6] = c + 1 < LINE_MAX ? int'(north2_buf[c + 1]) : 0;
            s1 = 0;
            other = 0;
            distinct = 1;
            for (int k = 1; k < 7; k++)
            begin
                if (nb[k] != nb[0])
                begin
                    if (distinct == 1)
                    begin
                        s1 = nb[k];
                        other = nb[k];
                        distinct = 2;
                    end
                    else if (nb[k] != other)
                        distinct = 3;
                end
            end
            binary = (distinct <= 2) && !esc_armed;
            esc_armed = 1'b0;
            // escape symbol: no pixel now, next residual finishes this one via GAP
            if (binary && res == 2)
            begin
                esc_armed = 1'b1;
                return;
            end
            if (binary && res == 0)
            begin
                pred = nb[0];
                res = 0;
            end
            else if (binary && res == 1)
            begin
                pred = s1;
                res = 0;
            end
            else
                pred = gap_pred(nb[0], nb[1], nb[2], nb[3], nb[4], nb[5], nb[6]);
        end
        else
        begin
            esc_armed = 1'b0;
            if (sh_mode == MODE_WEST)     pred = w;
            else if (sh_mode == MODE_AVG) pred = w / 2 + n / 2;
            else                          pred = n;   // north, and unknown modes
        end

        val = pred + res;
        if (val < 0) val = 0;
        if (val > int'(PIX_MAX)) val = int'(PIX_MAX);

        if (c < LINE_MAX)
        begin
            north2_buf[c] = north_buf[c];
            north_buf[c] = val[7:0];
        end
        west2_px = west_px;
        west_px = val[7:0];

        is_last = last_col && (r + 1 >= hgt);
        if (last_col)
        begin
            col = 0;
            row = is_last ? 0 : r + 1;
        end
        else
            col = c + 1;
        if (is_last) frames_done++;

        exp_px.pixel = val[7:0];
        exp_px.last_pixel = is_last;
        pixel_q.push_back(exp_px);
    endtask

    task automatic send_residual(input logic signed [8:0] res);
        residual_q.push_back(res);
        decode_residual(res);
        n_items++;
    endtask

    // Register write; the shadow follows at the transfer
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_WIDTH)       sh_width  = val[10:0];
        else if (idx == CFG_HEIGHT) sh_height = val;
        else if (idx == CFG_MODE)   sh_mode   = val[2:0];
    endtask

    task automatic configure(input int wid, input int hgt, input int mode);
        write_reg(CFG_WIDTH, 16'(wid));
        write_reg(CFG_HEIGHT, 16'(hgt));
        write_reg(CFG_MODE, 16'(mode));
    endtask

    // Sender holds off here until every expected pixel has been read back
    task automatic drain;
        do @(posedge clk); while (residual_q.size() != 0 || push || pixel_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Random residuals for one whole image; CALIC interior leans on symbols
    task automatic stream_image;
        int                frames0;
        int                pick;
        logic signed [8:0] res;
        frames0 = frames_done;
        while (frames_done == frames0)
        begin
            pick = $urandom_range(0, 99);
            if (sh_mode == MODE_CALIC && row >= 2 && pick < 55)
                res = 9'($urandom_range(0, 2));
            else if (pick < 75)
                res = 9'(int'($urandom_range(0, 8)) - 4);
            else
                res = 9'(int'($urandom_range(0, 510)) - 255);
            send_residual(res);
        end
    endtask

    // Starts a wide single-row image, then narrows it so the row closes early
    task automatic short_wide_row(input int n_px);
        for (int i = 0; i < n_px; i++)
            send_residual(9'(int'($urandom_range(0, 510)) - 255));
        drain();
        write_reg(CFG_WIDTH, 16'd3);
        send_residual(9'sd3);
        drain();
    endtask

    // Driver: keeps push up across back-to-back transfers
    always @(posedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full) n_sent++;
            if (!push || !full)
            begin
                if (residual_q.size() != 0 &&
                    ((n_sent >= 300 && n_sent < 450) || $urandom_range(0, 99) >= 21))
                begin
                    push     <= 1'b1;
                    residual <= residual_q.pop_front();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure, field-by-field compare
    always @(posedge clk)
    begin
        result_t exp_px;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                n_got++;
                if (pixel_q.size() == 0)
                begin
                    errors++;
                    $error("unexpected pixel %0d last_pixel %0b", pixel, last_pixel);
                end
                else
                begin
                    exp_px = pixel_q.pop_front();
                    if (pixel !== exp_px.pixel)
                    begin
                        errors++;
                        $error("pixel: expected %0d actual %0d", exp_px.pixel, pixel);
                    end
                    if (last_pixel !== exp_px.last_pixel)
                    begin
                        errors++;
                        $error("last_pixel: expected %0b actual %0b",
                               exp_px.last_pixel, last_pixel);
                    end
                end
            end
            pop <= (n_got >= 350 && n_got < 500) || $urandom_range(0, 99) >= 21;
        end
    end

    // Watchdog on transfer activity
    int quiet_cycles;
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_MAX)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int wid;
        int pick;
        errors = 0;
        n_sent = 0;
        n_got = 0;
        n_items = 0;
        frames_done = 0;
        rst_n = 1'b0;
        residual = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sh_width = WIDTH_RESET;
        sh_height = HEIGHT_RESET;
        sh_mode = MODE_WEST;
        west_px = '0;
        west2_px = '0;
        col = 0;
        row = 0;
        esc_armed = 1'b0;
        for (int i = 0; i < LINE_MAX; i++)
        begin
            north_buf[i] = '0;
            north2_buf[i] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Width 0 clamps to 3; residual extremes and saturation both ways
        configure(0, 2, MODE_WEST);
        send_residual(-9'sd255);
        send_residual(9'sd255);
        send_residual(9'sd0);
        send_residual(9'sd1);
        send_residual(-9'sd1);
        send_residual(-9'sd128);
        drain();

        // Tallest image, then shrink width mid-row: the column wraps and
        // height 1 closes the image on that pixel
        configure(8, 65535, MODE_CALIC);
        send_residual(9'sd10);
        for (int i = 0; i < 12; i++) send_residual(9'(i % 3 == 0 ? 3 : 0));
        drain();
        write_reg(CFG_WIDTH, 16'd4);
        write_reg(CFG_HEIGHT, 16'd1);
        send_residual(9'sd7);
        drain();

        // Flat image so the interior is binary: escape, then a GAP residual
        configure(4, 3, MODE_CALIC);
        for (int i = 0; i < 10; i++) send_residual(9'sd0);
        send_residual(9'sd2);
        send_residual(9'sd5);
        send_residual(9'sd1);
        drain();

        // Width field at its top, height 0 treated as 1; row cut short
        configure(2047, 0, MODE_AVG);
        short_wide_row(24);

        while (n_items < 520)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)      wid = $urandom_range(3, 12);
            else if (pick < 92) wid = $urandom_range(0, 2);
            else                wid = $urandom_range(13, 40);
            configure(wid,
                      $urandom_range(0, 99) < 5 ? 0 : $urandom_range(1, 6),
                      $urandom_range(0, 1) ? int'(MODE_CALIC) : $urandom_range(0, 7));
            stream_image();
            drain();
        end

        // Exact maximum width, row cut short
        configure(1024, 1, MODE_CALIC);
        short_wide_row(40);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
